>>> hw/rtl/can_mfr_pkg.sv
// ----------------------------------------------------------------------------
// can_mfr_pkg
// Shared types and constants of the CAN multiframe reassembler: frame tags,
// decoded operation codes and the command word passed from the decoder.
// ----------------------------------------------------------------------------
package can_mfr_pkg;

	// frame type tags carried in the first payload byte
	localparam logic [7:0] TAG_SINGLE = 8'h31;
	localparam logic [7:0] TAG_START  = 8'h10;
	localparam logic [7:0] TAG_DATA   = 8'h21;
	localparam logic [7:0] TAG_END    = 8'h22;

	// payload bytes per frame
	localparam int unsigned FRAME_PAY = 7;

	// decoded operation of one word
	typedef enum logic [2:0] {
		OP_NONE,
		OP_READ,
		OP_SINGLE,
		OP_START,
		OP_DATA,
		OP_END
	} op_t;

	// decoder result: operation and byte count of an end frame
	typedef struct packed {
		op_t        op;
		logic [3:0] end_len;
	} cmd_t;

endpackage

>>> hw/rtl/can_mfr_ram.sv
// ----------------------------------------------------------------------------
// can_mfr_ram
// Generic single-write, single-read RAM with registered read data. The read
// data register holds its value while re is low.
// ----------------------------------------------------------------------------
module can_mfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hw/rtl/can_mfr_decode.sv
// ----------------------------------------------------------------------------
// can_mfr_decode
// Classifies one input word (read request or frame type) and finds how many
// payload bytes an end frame carries: up to and including the last nonzero.
// ----------------------------------------------------------------------------
module can_mfr_decode (
	input  logic               kind,
	input  logic [7:0]         tag_byte,
	input  logic [6:0][7:0]    pay,
	output can_mfr_pkg::cmd_t  cmd
);

	import can_mfr_pkg::*;

	// operation from kind and tag; last nonzero payload byte, plus one
	// (zero when all bytes are zero)
	always_comb begin
		cmd.op      = OP_NONE;
		cmd.end_len = 4'd0;
		if (kind) begin
			cmd.op = OP_READ;
		end else begin
			case (tag_byte)
				TAG_SINGLE: cmd.op = OP_SINGLE;
				TAG_START:  cmd.op = OP_START;
				TAG_DATA:   cmd.op = OP_DATA;
				TAG_END:    cmd.op = OP_END;
				default:    cmd.op = OP_NONE;
			endcase
		end
		for (int i = 0; i < FRAME_PAY; i++) begin
			if (pay[i] != 8'h00) begin
				cmd.end_len = 4'(i + 1);
			end
		end
	end

endmodule

>>> hw/rtl/can_multiframe_reassembler_top.sv
// ----------------------------------------------------------------------------
// can_multiframe_reassembler_top
// Rebuilds segmented messages from tagged CAN frames and serves byte reads.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready): kind = 0 carries a frame (tag_byte
//   and pay0..pay6), kind = 1 reads the buffer byte at read_index.
//   Response channel (rsp_valid/rsp_ready): one word per request with the
//   complete flag and fill count after the request, and read_byte (zero for
//   frames and for positions never written since the last start frame).
//   rsp_valid rises once the request has passed the input and result
//   registers; one request is taken every cycle while rsp_ready is high.
//   The buffer is eight byte-wide banks interleaved on the low address
//   bits, so the payload bytes of a frame plus the terminating zero of an
//   end frame are written in the same cycle, at most one write per bank.
//   A high-water mark tells which bytes have been written since the last
//   start frame; bytes at or above it read as zero, so neither reset nor a start
//   frame needs a clearing pass and requests are taken right after reset.
//   Reset clears the fill count, complete flag, mark and both stage valids.
//   When rsp_ready is low the response is held and the input stage takes one
//   more request, then req_ready drops until the response is taken.
// ----------------------------------------------------------------------------
module can_multiframe_reassembler_top #(
	parameter int BUF_BYTES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  logic       kind,
	input  logic [7:0] tag_byte,
	input  logic [7:0] pay0,
	input  logic [7:0] pay1,
	input  logic [7:0] pay2,
	input  logic [7:0] pay3,
	input  logic [7:0] pay4,
	input  logic [7:0] pay5,
	input  logic [7:0] pay6,
	input  logic [7:0] read_index,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output logic       complete,
	output logic [8:0] length,
	output logic [7:0] read_byte
);

	import can_mfr_pkg::*;

	localparam int NBANK = 8;
	localparam int AW    = $clog2(BUF_BYTES);
	localparam int CW    = AW + 1;
	localparam int WW    = CW + 1;
	localparam int DEPTH = (BUF_BYTES + NBANK - 1) / NBANK;
	localparam int RW    = $clog2(DEPTH);
	localparam int IW    = (CW > 8) ? CW : 8;

	// input stage
	logic           valid_s1;
	logic           kind_s1;
	logic [7:0]     tag_s1;
	logic [6:0][7:0] pay_s1;
	logic [7:0]     idx_s1;

	// message state
	logic [CW-1:0]  fill_q;
	logic [CW-1:0]  hw_q;
	logic           complete_q;

	// result stage
	logic           valid_s2;
	logic           complete_s2;
	logic [8:0]     length_s2;
	logic           hit_s2;
	logic [2:0]     bank_s2;

	logic           advance;
	logic           go;
	cmd_t           cmd;

	// next state
	logic [WW-1:0]  fill_w;
	logic [WW-1:0]  hw_w;
	logic [WW-1:0]  buf_w;
	logic [WW-1:0]  data_top;
	logic [WW-1:0]  end_top;
	logic [WW-1:0]  end_mark;
	logic [WW-1:0]  base_w;
	logic           room;
	logic           frame_ok;
	logic [3:0]     wr_lim;
	logic [3:0]     dat_lim;
	logic [CW-1:0]  fill_d;
	logic [CW-1:0]  hw_d;
	logic           complete_d;

	// bank ports
	logic [7:0][7:0]        pay8;
	logic [NBANK-1:0]       we;
	logic [NBANK-1:0][2:0]  k_b;
	logic [NBANK-1:0][WW-1:0] addr_b;
	logic [NBANK-1:0][RW-1:0] waddr;
	logic [NBANK-1:0][7:0]  wdata;
	logic [NBANK-1:0][7:0]  rdata;

	// read path
	logic [IW-1:0]  idx_w;
	logic [IW-1:0]  hw_x;
	logic [RW-1:0]  rd_row;
	logic           rd_hit;
	logic           re;

	// handshake
	assign advance   = !valid_s2 || rsp_ready;
	assign go        = valid_s1 && advance;
	assign req_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && req_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			kind_s1 <= kind;
			tag_s1  <= tag_byte;
			pay_s1  <= {pay6, pay5, pay4, pay3, pay2, pay1, pay0};
			idx_s1  <= read_index;
		end
	end

	can_mfr_decode u_decode (
		.kind     (kind_s1),
		.tag_byte (tag_s1),
		.pay      (pay_s1),
		.cmd      (cmd)
	);

	// sums for the room check and the new mark
	assign fill_w   = WW'(fill_q);
	assign hw_w     = WW'(hw_q);
	assign buf_w    = WW'(BUF_BYTES);
	assign data_top = fill_w + WW'(FRAME_PAY);
	assign room     = data_top <= buf_w;
	assign end_top  = fill_w + WW'(cmd.end_len) + WW'(1);
	assign end_mark = (end_top > buf_w) ? buf_w : end_top;

	// state update and write window per operation
	always_comb begin
		fill_d     = fill_q;
		hw_d       = hw_q;
		complete_d = complete_q;
		frame_ok   = 1'b0;
		base_w     = fill_w;
		wr_lim     = 4'd0;
		dat_lim    = 4'd0;
		case (cmd.op)
			OP_SINGLE: begin
				frame_ok   = 1'b1;
				base_w     = '0;
				fill_d     = CW'(FRAME_PAY);
				complete_d = 1'b1;
				wr_lim     = 4'(FRAME_PAY);
				dat_lim    = 4'(FRAME_PAY);
				if (hw_q < CW'(FRAME_PAY)) begin
					hw_d = CW'(FRAME_PAY);
				end
			end
			OP_START: begin
				frame_ok   = 1'b1;
				base_w     = '0;
				fill_d     = CW'(FRAME_PAY);
				complete_d = 1'b0;
				hw_d       = CW'(FRAME_PAY);
				wr_lim     = 4'(FRAME_PAY);
				dat_lim    = 4'(FRAME_PAY);
			end
			OP_DATA: begin
				if (room) begin
					frame_ok = 1'b1;
					fill_d   = CW'(data_top);
					wr_lim   = 4'(FRAME_PAY);
					dat_lim  = 4'(FRAME_PAY);
					if (data_top > hw_w) begin
						hw_d = CW'(data_top);
					end
				end
			end
			OP_END: begin
				if (room) begin
					frame_ok   = 1'b1;
					fill_d     = CW'(fill_w + WW'(cmd.end_len));
					complete_d = 1'b1;
					wr_lim     = cmd.end_len + 4'd1;
					dat_lim    = cmd.end_len;
					if (end_mark > hw_w) begin
						hw_d = CW'(end_mark);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// byte k goes to bank (base + k) mod 8; the end zero is byte k = end_len
	assign pay8 = {8'h00, pay_s1};

	for (genvar b = 0; b < NBANK; b++) begin : g_bank
		assign k_b[b]    = 3'(b) - base_w[2:0];
		assign addr_b[b] = base_w + WW'(k_b[b]);
		assign we[b]     = go && frame_ok && ({1'b0, k_b[b]} < wr_lim)
		                   && (addr_b[b] < buf_w);
		assign waddr[b]  = addr_b[b][RW+2:3];
		assign wdata[b]  = ({1'b0, k_b[b]} < dat_lim) ? pay8[k_b[b]] : 8'h00;

		can_mfr_ram #(
			.WIDTH (8),
			.DEPTH (DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (we[b]),
			.waddr (waddr[b]),
			.wdata (wdata[b]),
			.re    (re),
			.raddr (rd_row),
			.rdata (rdata[b])
		);
	end

	// read request: bytes at or above the mark read as zero
	assign idx_w  = IW'(idx_s1);
	assign hw_x   = IW'(hw_q);
	assign rd_row = idx_w[RW+2:3];
	assign rd_hit = (cmd.op == OP_READ) && (idx_w < hw_x);
	assign re     = go && (cmd.op == OP_READ);

	// message state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			hw_q       <= '0;
			complete_q <= 1'b0;
		end else if (go) begin
			fill_q     <= fill_d;
			hw_q       <= hw_d;
			complete_q <= complete_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			complete_s2 <= complete_d;
			length_s2   <= 9'(fill_d);
			hit_s2      <= rd_hit;
			bank_s2     <= idx_s1[2:0];
		end
	end

	assign rsp_valid = valid_s2;
	assign complete  = complete_s2;
	assign length    = length_s2;
	assign read_byte = hit_s2 ? rdata[bank_s2] : 8'h00;

	// fill count never passes the written mark, so bytes below it are live
	a_fill_below_mark: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= hw_q)
		else $error("fill count above high-water mark");

	a_mark_in_buffer: assert property (@(posedge clk) disable iff (!arst_n)
		hw_q <= CW'(BUF_BYTES))
		else $error("high-water mark beyond buffer");

	a_start_resets: assert property (@(posedge clk) disable iff (!arst_n)
		go && (cmd.op == OP_START) |=>
			(fill_q == CW'(FRAME_PAY)) && (hw_q == CW'(FRAME_PAY)) && !complete_q)
		else $error("start frame did not reopen the message");

	a_write_only_on_go: assert property (@(posedge clk) disable iff (!arst_n)
		!go |-> (we == '0))
		else $error("bank write without an advancing word");

endmodule
